/* hw/rtl/bpts_pkg.sv */
// Shared types, constants and helper functions for the bitmap priority task scheduler.
// No dependencies.

package bpts_pkg;

    localparam int NUM_PRIORITIES = 32;
    localparam int PRIO_W         = $clog2(NUM_PRIORITIES);
    localparam int MASK_W         = 31;
    localparam int CNT_W          = 8;

    localparam logic [PRIO_W-1:0] LAST_PRIO = PRIO_W'(NUM_PRIORITIES - 1);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DELAY = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SCHED = 2'd3;

    typedef struct packed {
        logic              start;
        logic [MASK_W-1:0] waiting;
        logic              wr_en;
        logic [PRIO_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
    } t_walk_req;

    typedef struct packed {
        logic              done;
        logic [MASK_W-1:0] wake;
    } t_walk_stat;

    // One-hot mask bit for priority p (p >= 1).
    function automatic logic [MASK_W-1:0] prio_bit(input logic [PRIO_W-1:0] p);
        return MASK_W'(1) << (p - PRIO_W'(1));
    endfunction

    // Highest set priority in a ready bitmap, 0 (idle) when empty.
    function automatic logic [PRIO_W-1:0] highest_ready(input logic [MASK_W-1:0] bits);
        logic [PRIO_W-1:0] best;
        best = '0;
        for (int p = 1; p <= MASK_W; p++) begin
            if (bits[p-1]) begin
                best = PRIO_W'(p);
            end
        end
        return best;
    endfunction

endpackage

/* hw/rtl/bpts_if.sv */
// Request and response channel interfaces of the scheduler.
// Depends on bpts_pkg.

interface bpts_req_if import bpts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [PRIO_W-1:0] task_priority;
    logic [CNT_W-1:0]  tick_count;

    modport source (output valid, output opcode, output task_priority, output tick_count,
                    input ready);
    modport sink   (input valid, input opcode, input task_priority, input tick_count,
                    output ready);
endinterface

interface bpts_rsp_if import bpts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PRIO_W-1:0] next_task;
    logic              switch_now;
    logic [MASK_W-1:0] ready_mask;
    logic [MASK_W-1:0] waiting_mask;
    logic              bad_request;

    modport source (output valid, output next_task, output switch_now, output ready_mask,
                    output waiting_mask, output bad_request, input ready);
    modport sink   (input valid, input next_task, input switch_now, input ready_mask,
                    input waiting_mask, input bad_request, output ready);
endinterface

/* hw/rtl/bpts_tick_walker.sv */
// Sleep counter memory and the tick sweep that counts waiting tasks down.
// Depends on bpts_pkg.

module bpts_tick_walker import bpts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_walk_req  i_req,
    output t_walk_stat o_stat
);

    logic [CNT_W-1:0]  mem [NUM_PRIORITIES];

    logic              r_active;
    logic [PRIO_W-1:0] r_rd_idx;
    logic [CNT_W-1:0]  r_rd_data;
    logic              r_wb_valid;
    logic [PRIO_W-1:0] r_wb_idx;
    logic [MASK_W-1:0] r_wait;
    logic [MASK_W-1:0] r_wake;

    logic              wb_hit;
    logic [CNT_W-1:0]  dec;
    logic [MASK_W-1:0] wake_bit;

    // Write-back stage trails the read by one entry, so the two never meet.
    always_comb begin
        wb_hit   = r_wb_valid && r_wait[r_wb_idx - PRIO_W'(1)];
        dec      = r_rd_data - CNT_W'(1);
        wake_bit = (wb_hit && (dec == '0)) ? prio_bit(r_wb_idx) : '0;
        o_stat.wake = r_wake | wake_bit;
        o_stat.done = r_wb_valid && (r_wb_idx == LAST_PRIO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_wb_valid <= 1'b0;
            r_rd_idx   <= '0;
            r_wb_idx   <= '0;
        end else begin
            r_wb_valid <= r_active;
            r_wb_idx   <= r_rd_idx;
            if (i_req.start) begin
                r_active <= 1'b1;
                r_rd_idx <= PRIO_W'(1);
            end else if (r_active) begin
                r_rd_idx <= r_rd_idx + PRIO_W'(1);
                if (r_rd_idx == LAST_PRIO) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_wait <= i_req.waiting;
            r_wake <= '0;
        end else if (r_wb_valid) begin
            r_wake <= o_stat.wake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end else if (wb_hit) begin
            mem[r_wb_idx] <= dec;
        end
        r_rd_data <= mem[r_rd_idx];
    end

endmodule

/* hw/rtl/bitmap_priority_task_scheduler.sv */
// Start, delay and schedule: the response is registered and valid in the cycle after acceptance.
// Tick: the response follows the sweep over the sleep counter memory
// (one read a cycle for entries 1 to NUM_PRIORITIES-1, then the last write-back).
// One transaction at a time; the next is taken in the cycle its response is taken.
// Synchronous active-low reset clears bitmaps, running task and handshake state;
// sleep counters are not cleared and hold garbage until a delay writes them.

module bitmap_priority_task_scheduler import bpts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpts_req_if.sink   i_req,
    bpts_rsp_if.source o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TICK = 1'b1;

    logic              r_state,    n_state;
    logic [MASK_W-1:0] r_ready,    n_ready;
    logic [MASK_W-1:0] r_waiting,  n_waiting;
    logic [PRIO_W-1:0] r_run_task, n_run_task;
    logic              r_run_valid, n_run_valid;

    logic              r_out_valid, n_out_valid;
    logic [PRIO_W-1:0] r_out_task;
    logic              r_out_sw;
    logic [MASK_W-1:0] r_out_ready;
    logic [MASK_W-1:0] r_out_waiting;
    logic              r_out_bad;

    logic              accept;
    logic              load;
    logic              res_sw;
    logic              res_bad;
    logic              prio_ok;
    logic [MASK_W-1:0] dly_ready;
    logic [PRIO_W-1:0] best;

    t_walk_req         walk_req;
    t_walk_stat        walk_stat;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign prio_ok = (i_req.task_priority != '0)
                  && ({1'b0, i_req.task_priority} < (PRIO_W + 1)'(NUM_PRIORITIES));

    always_comb begin
        n_state     = r_state;
        n_ready     = r_ready;
        n_waiting   = r_waiting;
        n_run_task  = r_run_task;
        n_run_valid = r_run_valid;
        load        = 1'b0;
        res_sw      = 1'b0;
        res_bad     = 1'b0;
        dly_ready   = r_ready & ~prio_bit(r_run_task);
        best        = '0;

        walk_req.start   = 1'b0;
        walk_req.waiting = r_waiting;
        walk_req.wr_en   = 1'b0;
        walk_req.wr_addr = r_run_task;
        walk_req.wr_data = i_req.tick_count;

        if (accept) begin
            unique case (i_req.opcode)
                OP_START: begin
                    load = 1'b1;
                    if (prio_ok) begin
                        n_ready = r_ready | prio_bit(i_req.task_priority);
                    end
                end
                OP_DELAY: begin
                    load = 1'b1;
                    if (!r_run_valid || (r_run_task == '0)) begin
                        res_bad = 1'b1;
                    end else begin
                        // Sleep the running task, then pick again from what stays ready.
                        walk_req.wr_en = 1'b1;
                        best           = highest_ready(dly_ready);
                        n_ready        = dly_ready;
                        n_waiting      = r_waiting | prio_bit(r_run_task);
                        n_run_task     = best;
                        res_sw         = (best != r_run_task);
                    end
                end
                OP_TICK: begin
                    walk_req.start = 1'b1;
                    n_state        = S_TICK;
                end
                OP_SCHED: begin
                    load        = 1'b1;
                    best        = highest_ready(r_ready);
                    res_sw      = !r_run_valid || (best != r_run_task);
                    n_run_task  = best;
                    n_run_valid = 1'b1;
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end else if ((r_state == S_TICK) && walk_stat.done) begin
            load      = 1'b1;
            n_state   = S_IDLE;
            n_ready   = r_ready | walk_stat.wake;
            n_waiting = r_waiting & ~walk_stat.wake;
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= '0;
            r_waiting   <= '0;
            r_run_task  <= '0;
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_waiting   <= n_waiting;
            r_run_task  <= n_run_task;
            r_run_valid <= n_run_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_task    <= n_run_task;
            r_out_sw      <= res_sw;
            r_out_ready   <= n_ready;
            r_out_waiting <= n_waiting;
            r_out_bad     <= res_bad;
        end
    end

    bpts_tick_walker u_tick_walker (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (walk_req),
        .o_stat (walk_stat)
    );

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.next_task    = r_out_task;
    assign o_rsp.switch_now   = r_out_sw;
    assign o_rsp.ready_mask   = r_out_ready;
    assign o_rsp.waiting_mask = r_out_waiting;
    assign o_rsp.bad_request  = r_out_bad;

endmodule

/* hw/rtl/bpts_checker.sv */
// Port-level assertions for the scheduler, bound to the top level.
// Depends on bpts_pkg and bitmap_priority_task_scheduler.

module bpts_checker import bpts_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [PRIO_W-1:0] i_next_task,
    input logic              i_switch_now,
    input logic [MASK_W-1:0] i_ready_mask,
    input logic              i_bad_request
);

    // A stalled response holds its task, switch flag and ready mask.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_next_task)
            && $stable(i_switch_now) && $stable(i_ready_mask))
        else $error("response changed while stalled");

    // No new transaction while a response is still unclaimed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("request taken while response stalled");

    // A rejected delay never requests a switch.
    a_bad_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_bad_request |-> !i_switch_now)
        else $error("switch on rejected delay");

    // A switch to a real task goes to a ready one.
    a_switch_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_switch_now && (i_next_task != '0)
            |-> i_ready_mask[i_next_task - PRIO_W'(1)])
        else $error("switch to a task that is not ready");

    // Reset drops any pending response.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind bitmap_priority_task_scheduler bpts_checker u_bpts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_next_task  (o_rsp.next_task),
    .i_switch_now (o_rsp.switch_now),
    .i_ready_mask (o_rsp.ready_mask),
    .i_bad_request(o_rsp.bad_request)
);
